/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the compressor rtl
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ADRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((ante) |-> (cons))) else $error(msg);

// antecedent implies consequent in the next cycle
`define ADRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((ante) |=> (cons))) else $error(msg);

`endif

/* hw/rtl/adrc_pkg.sv */
// ----------------------------------------------------------------------------
// adrc_pkg
// types, constants and the microcode program of the compressor
// ----------------------------------------------------------------------------
`default_nettype none

package adrc_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned GainW   = 17;
  localparam int unsigned StepW   = 4;
  localparam int unsigned DivSteps = 24;
  localparam int unsigned CntW    = $clog2(DivSteps + 1);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [GainW-1:0] GainOne     = 17'h10000;
  localparam logic [DataW-1:0] ThrReset    = 16'd0;
  localparam logic [DataW-1:0] RatioReset  = 16'd256;
  localparam logic [DataW-1:0] ReleaseReset = 16'd13107;
  localparam logic [DataW-1:0] RatioMin    = 16'd256;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRatio     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRelease   = 2'd2;

  // program addresses
  localparam logic [StepW-1:0] StepWait  = 4'd0;
  localparam logic [StepW-1:0] StepEnv   = 4'd1;
  localparam logic [StepW-1:0] StepMulR  = 4'd2;
  localparam logic [StepW-1:0] StepDecay = 4'd3;
  localparam logic [StepW-1:0] StepThr   = 4'd4;
  localparam logic [StepW-1:0] StepMulD  = 4'd5;
  localparam logic [StepW-1:0] StepDiv   = 4'd6;
  localparam logic [StepW-1:0] StepGain  = 4'd7;
  localparam logic [StepW-1:0] StepMulO  = 4'd8;
  localparam logic [StepW-1:0] StepOut   = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_ENV,
    OP_MUL,
    OP_DECAY,
    OP_THR,
    OP_DIV,
    OP_GAIN,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    MUL_DECAY,
    MUL_DEN,
    MUL_OUT
  } mul_sel_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_IN_ACC,
    COND_MAG_GT,
    COND_ENV_LE_THR,
    COND_CNT_LAST,
    COND_OUT_FREE
  } cond_e;

  // one control word: operation, multiplier operands, branch
  typedef struct packed {
    op_e              op;
    mul_sel_e         mul_sel;
    cond_e            cond;
    logic             hold;
    logic [StepW-1:0] target;
  } ctl_word_t;

  // datapath flags used by the branch logic
  typedef struct packed {
    logic in_acc;
    logic mag_gt;
    logic env_le_thr;
    logic cnt_last;
    logic out_free;
  } dp_status_t;

  // microcode program
  function automatic ctl_word_t ucode_rom(input logic [StepW-1:0] step);
    ctl_word_t w;
    unique case (step)
      StepWait:  w = '{op: OP_WAIT,  mul_sel: MUL_DECAY, cond: COND_IN_ACC,
                      hold: 1'b1, target: StepEnv};
      StepEnv:   w = '{op: OP_ENV,   mul_sel: MUL_DECAY, cond: COND_MAG_GT,
                      hold: 1'b0, target: StepThr};
      StepMulR:  w = '{op: OP_MUL,   mul_sel: MUL_DECAY, cond: COND_NONE,
                      hold: 1'b0, target: StepWait};
      StepDecay: w = '{op: OP_DECAY, mul_sel: MUL_DECAY, cond: COND_NONE,
                      hold: 1'b0, target: StepWait};
      StepThr:   w = '{op: OP_THR,   mul_sel: MUL_DECAY, cond: COND_ENV_LE_THR,
                      hold: 1'b0, target: StepMulO};
      StepMulD:  w = '{op: OP_MUL,   mul_sel: MUL_DEN,   cond: COND_NONE,
                      hold: 1'b0, target: StepWait};
      StepDiv:   w = '{op: OP_DIV,   mul_sel: MUL_DEN,   cond: COND_CNT_LAST,
                      hold: 1'b1, target: StepGain};
      StepGain:  w = '{op: OP_GAIN,  mul_sel: MUL_DEN,   cond: COND_NONE,
                      hold: 1'b0, target: StepWait};
      StepMulO:  w = '{op: OP_MUL,   mul_sel: MUL_OUT,   cond: COND_NONE,
                      hold: 1'b0, target: StepWait};
      StepOut:   w = '{op: OP_OUT,   mul_sel: MUL_OUT,   cond: COND_OUT_FREE,
                      hold: 1'b1, target: StepWait};
      default:   w = '{op: OP_NOP,   mul_sel: MUL_DECAY, cond: COND_ALWAYS,
                      hold: 1'b0, target: StepWait};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/adrc_useq.sv */
// ----------------------------------------------------------------------------
// adrc_useq
// step counter and microcode lookup with conditional branching
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module adrc_useq (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire adrc_pkg::dp_status_t   status_i,
  output adrc_pkg::ctl_word_t         ctl_o
);

  logic [adrc_pkg::StepW-1:0] step_q, step_d;
  logic                       take;

  // fetch the control word of the current step
  assign ctl_o = adrc_pkg::ucode_rom(step_q);

  // branch condition select
  always_comb begin
    unique case (ctl_o.cond)
      adrc_pkg::COND_NONE:       take = 1'b0;
      adrc_pkg::COND_ALWAYS:     take = 1'b1;
      adrc_pkg::COND_IN_ACC:     take = status_i.in_acc;
      adrc_pkg::COND_MAG_GT:     take = status_i.mag_gt;
      adrc_pkg::COND_ENV_LE_THR: take = status_i.env_le_thr;
      adrc_pkg::COND_CNT_LAST:   take = status_i.cnt_last;
      adrc_pkg::COND_OUT_FREE:   take = status_i.out_free;
      default:                   take = 1'b0;
    endcase
  end

  // next step: jump, hold or fall through
  always_comb begin
    priority if (take) begin
      step_d = ctl_o.target;
    end else if (ctl_o.hold) begin
      step_d = step_q;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= adrc_pkg::StepWait;
    end else begin
      step_q <= step_d;
    end
  end

  `ADRC_ASSERT_NEXT(a_accept_starts_env,
    (ctl_o.op == adrc_pkg::OP_WAIT) && status_i.in_acc,
    step_q == adrc_pkg::StepEnv, "accepted word did not start envelope step")
  `ADRC_ASSERT_NEXT(a_div_loops,
    (ctl_o.op == adrc_pkg::OP_DIV) && !status_i.cnt_last,
    step_q == adrc_pkg::StepDiv, "divider left its loop early")

endmodule

`default_nettype wire

/* hw/rtl/adrc_datapath.sv */
// ----------------------------------------------------------------------------
// adrc_datapath
// config registers, envelope, shared multiplier, restoring divider, output
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module adrc_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [adrc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [adrc_pkg::DataW-1:0]          cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [adrc_pkg::DataW-1:0]   sample_in_i,
  input  wire logic                                start_of_block_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [adrc_pkg::DataW-1:0]        sample_out_o,
  output logic [adrc_pkg::GainW-1:0]               gain_applied_o,
  input  wire adrc_pkg::ctl_word_t                 ctl_i,
  output adrc_pkg::dp_status_t                     status_o
);

  localparam int unsigned DW = adrc_pkg::DataW;
  localparam int unsigned GW = adrc_pkg::GainW;
  localparam int unsigned PW = 2 * DW;

  // configuration
  logic [DW-1:0] thr_q, ratio_q, rel_q;
  logic [DW-1:0] ratio_eff;

  // working registers
  logic signed [DW-1:0] x_q;
  logic [DW-1:0]        mag_q, env_q, diff_q;
  logic [DW-1:0]        mag_in;
  logic signed [GW:0]   mul_a, mul_b;
  logic signed [2*GW+1:0] mul_q;
  logic [PW-1:0]        rem_q;
  logic [GW-1:0]        quo_q, gain_q;
  logic [adrc_pkg::CntW-1:0] cnt_q;
  logic signed [DW-1:0] sout_q;
  logic [GW-1:0]        gout_q;
  logic                 out_valid_q;

  logic          in_acc, out_free, out_load;
  logic [PW:0]   rem_sh, den_ext, rem_sub;
  logic          rem_ge;
  logic [PW-1:0] decay;

  // handshake
  assign in_ready_o = (ctl_i.op == adrc_pkg::OP_WAIT);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (ctl_i.op == adrc_pkg::OP_OUT) && out_free;

  // rectify the incoming sample, full-scale negative gives 32768
  assign mag_in = sample_in_i[DW-1] ? (~sample_in_i + 1'b1) : sample_in_i;

  // ratio below unity is treated as unity
  assign ratio_eff = (ratio_q < adrc_pkg::RatioMin) ? adrc_pkg::RatioMin : ratio_q;

  // shared multiplier operand select
  always_comb begin
    unique case (ctl_i.mul_sel)
      adrc_pkg::MUL_DECAY: begin
        mul_a = {2'b00, rel_q};
        mul_b = {2'b00, diff_q};
      end
      adrc_pkg::MUL_DEN: begin
        mul_a = {2'b00, env_q};
        mul_b = {2'b00, ratio_eff};
      end
      adrc_pkg::MUL_OUT: begin
        mul_a = {{2{x_q[DW-1]}}, x_q};
        mul_b = {1'b0, gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // envelope release: env - r*(env-mag)/2^16, floored
  assign decay = {env_q, {DW{1'b0}}} - mul_q[PW-1:0];

  // one restoring division step against the product env*ratio
  assign rem_sh  = {rem_q, 1'b0};
  assign den_ext = {1'b0, mul_q[PW-1:0]};
  assign rem_ge  = (rem_sh >= den_ext);
  assign rem_sub = rem_sh - den_ext;

  // status flags for the sequencer
  assign status_o.in_acc     = in_acc;
  assign status_o.mag_gt     = (mag_q > env_q);
  assign status_o.env_le_thr = (env_q <= thr_q);
  assign status_o.cnt_last   = (cnt_q == adrc_pkg::CntW'(1));
  assign status_o.out_free   = out_free;

  // configuration writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= adrc_pkg::ThrReset;
      ratio_q <= adrc_pkg::RatioReset;
      rel_q   <= adrc_pkg::ReleaseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        adrc_pkg::RegThreshold: thr_q   <= cfg_wdata_i;
        adrc_pkg::RegRatio:     ratio_q <= cfg_wdata_i;
        adrc_pkg::RegRelease:   rel_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // envelope state, divider count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (ctl_i.op)
        adrc_pkg::OP_WAIT: begin
          if (in_acc && start_of_block_i) begin
            env_q <= '0;
          end
        end
        adrc_pkg::OP_ENV: begin
          if (mag_q > env_q) begin
            env_q <= mag_q;
          end
        end
        adrc_pkg::OP_DECAY: env_q <= decay[PW-1:DW];
        adrc_pkg::OP_THR:   cnt_q <= adrc_pkg::CntW'(adrc_pkg::DivSteps);
        adrc_pkg::OP_DIV:   cnt_q <= cnt_q - 1'b1;
        adrc_pkg::OP_NOP, adrc_pkg::OP_MUL, adrc_pkg::OP_GAIN,
        adrc_pkg::OP_OUT: ;
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      adrc_pkg::OP_WAIT: begin
        if (in_acc) begin
          x_q   <= sample_in_i;
          mag_q <= mag_in;
        end
      end
      adrc_pkg::OP_ENV:  diff_q <= env_q - mag_q;
      adrc_pkg::OP_MUL:  mul_q  <= mul_a * mul_b;
      adrc_pkg::OP_THR: begin
        gain_q <= adrc_pkg::GainOne;
        rem_q  <= {{(PW-DW){1'b0}}, env_q - thr_q};
        quo_q  <= '0;
      end
      adrc_pkg::OP_DIV: begin
        rem_q <= rem_ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
        quo_q <= {quo_q[GW-2:0], rem_ge};
      end
      adrc_pkg::OP_GAIN: begin
        gain_q <= quo_q[GW-1] ? '0 : (adrc_pkg::GainOne - quo_q);
      end
      adrc_pkg::OP_OUT: begin
        if (out_free) begin
          sout_q <= mul_q[PW-1:DW];
          gout_q <= gain_q;
        end
      end
      adrc_pkg::OP_NOP, adrc_pkg::OP_DECAY: ;
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sout_q;
  assign gain_applied_o = gout_q;

  `ADRC_ASSERT_IMPL(a_rem_below_den, ctl_i.op == adrc_pkg::OP_DIV,
    rem_q < mul_q[PW-1:0], "divider remainder not below divisor")
  `ADRC_ASSERT_NEXT(a_decay_no_rise, ctl_i.op == adrc_pkg::OP_DECAY,
    env_q <= $past(env_q), "envelope rose during release")
  `ADRC_ASSERT_IMPL(a_gain_range, out_valid_q,
    gout_q <= adrc_pkg::GainOne, "output gain above unity")

endmodule

`default_nettype wire

/* hw/rtl/audio_dynamic_range_compressor.sv */
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor
// peak envelope feed-forward compressor, microcoded sequencer over one datapath
// ----------------------------------------------------------------------------
//  channel   signals                                    direction
//  input     in_valid_i/in_ready_o, sample_in_i,        in
//            start_of_block_i
//  output    out_valid_o/out_ready_i, sample_out_o,     out
//            gain_applied_o
//  config    cfg_we_i, cfg_index_i, cfg_wdata_i         in, write only
//
//  a word skips the divider when the envelope is at or below threshold; above
//  it the word runs through the 24-step restoring divider loop
//  the next word is taken as soon as the result sits in the output register,
//  which holds it until the sink takes it; a full output register stalls the
//  program at its output step
//  reset clears the envelope, the program counter and restores register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module audio_dynamic_range_compressor (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [adrc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [adrc_pkg::DataW-1:0]          cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [adrc_pkg::DataW-1:0]   sample_in_i,
  input  wire logic                                start_of_block_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [adrc_pkg::DataW-1:0]        sample_out_o,
  output logic [adrc_pkg::GainW-1:0]               gain_applied_o
);

  adrc_pkg::ctl_word_t  ctl;
  adrc_pkg::dp_status_t status;

  // program sequencer
  adrc_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  // datapath
  adrc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_in_i      (sample_in_i),
    .start_of_block_i (start_of_block_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_out_o     (sample_out_o),
    .gain_applied_o   (gain_applied_o),
    .ctl_i            (ctl),
    .status_o         (status)
  );

endmodule

`default_nettype wire

/* tb/sv/compressor_result_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compressor_result_monitor
// watches the config port and both word channels of the compressor, keeps its
// own envelope and register copies, predicts each output word at input
// acceptance and compares it field by field with what the block returns
// ----------------------------------------------------------------------------

module compressor_result_monitor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adrc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [adrc_pkg::DataW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [adrc_pkg::DataW-1:0]   sample_in_i,
  input  logic                                start_of_block_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [adrc_pkg::DataW-1:0]   sample_out_i,
  input  logic [adrc_pkg::GainW-1:0]          gain_applied_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  words_o,
  output int                                  reduced_o,
  output int                                  muted_o
);
  import adrc_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic [GainW-1:0]        gain;
  } comp_word_t;

  // register copies and peak envelope
  logic [DataW-1:0] thr_cfg;
  logic [DataW-1:0] ratio_cfg;
  logic [DataW-1:0] rel_cfg;
  logic [DataW-1:0] env_lvl;

  comp_word_t predicted_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    words_o      = 0;
    reduced_o    = 0;
    muted_o      = 0;
  end

  // gain for a given envelope, q1.16, clamped at zero
  function automatic logic [GainW-1:0] gain_for(input logic [DataW-1:0] env);
    logic [DataW-1:0] ratio;
    logic [63:0]      num;
    logic [63:0]      den;
    logic [63:0]      quot;
    ratio = (ratio_cfg < RatioMin) ? RatioMin : ratio_cfg;
    if (env <= thr_cfg) return GainOne;
    num  = 64'(env - thr_cfg) << 24;
    den  = 64'(env) * 64'(ratio);
    quot = num / den;
    if (quot >= 64'(GainOne)) return '0;
    return GainOne - quot[GainW-1:0];
  endfunction

  // advance the envelope with one sample and work out the output word
  function automatic comp_word_t compress_word(input logic signed [DataW-1:0] x,
                                               input logic sob);
    comp_word_t  w;
    logic [16:0] mag;
    logic [63:0] acc;
    longint      prod;
    longint      y;
    if (sob) env_lvl = '0;
    mag = (x < 0) ? 17'(-int'(x)) : 17'(int'(x));
    if (mag > {1'b0, env_lvl}) begin
      env_lvl = mag[DataW-1:0];
    end else begin
      acc = 64'(env_lvl) * (64'(GainOne) - 64'(rel_cfg)) + 64'(mag) * 64'(rel_cfg);
      env_lvl = acc[31:16];
    end
    w.gain   = gain_for(env_lvl);
    prod     = longint'(x) * longint'(w.gain);
    // arithmetic shift floors toward minus infinity
    y        = prod >>> 16;
    w.sample = y[DataW-1:0];
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    comp_word_t exp_w;
    if (!rst_ni) begin
      thr_cfg   = ThrReset;
      ratio_cfg = RatioReset;
      rel_cfg   = ReleaseReset;
      env_lvl   = '0;
      predicted_q.delete();
      pending_o = 0;
    end else begin
      // register writes, unmapped indexes fall through
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegThreshold: thr_cfg   = cfg_wdata_i;
          RegRatio:     ratio_cfg = cfg_wdata_i;
          RegRelease:   rel_cfg   = cfg_wdata_i;
          default: ;
        endcase
      end

      // input word accepted
      if (in_valid_i && in_ready_i) begin
        predicted_q.push_back(compress_word(sample_in_i, start_of_block_i));
      end

      // output word accepted
      if (out_valid_i && out_ready_i) begin
        if (predicted_q.size() == 0) begin
          fail_count_o++;
          $error("output word with nothing predicted: sample_out %0d gain_applied %0d",
                 sample_out_i, gain_applied_i);
        end else begin
          exp_w = predicted_q.pop_front();
          words_o++;
          if (exp_w.gain < GainOne) reduced_o++;
          if (exp_w.gain == '0) muted_o++;
          if (sample_out_i !== exp_w.sample) begin
            fail_count_o++;
            $error("sample_out mismatch: expected %0d, actual %0d",
                   $signed(exp_w.sample), sample_out_i);
          end
          if (gain_applied_i !== exp_w.gain) begin
            fail_count_o++;
            $error("gain_applied mismatch: expected %0d, actual %0d",
                   exp_w.gain, gain_applied_i);
          end
        end
      end

      pending_o = predicted_q.size();
    end
  end

endmodule

/* tb/sv/audio_dynamic_range_compressor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor_tb
// drives the compressor with directed corner words and long runs of random
// bursts under several register settings, with random gaps and sink stalls;
// the result monitor predicts and checks every output word
// ----------------------------------------------------------------------------

module audio_dynamic_range_compressor_tb;
  import adrc_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int TailCycles = 40;
  localparam int PhaseWords = 137;
  localparam int NumPhases  = 8;

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [DataW-1:0]          cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [DataW-1:0]   sample_in_i = '0;
  logic                      start_of_block_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [DataW-1:0]   sample_out_o;
  logic [GainW-1:0]          gain_applied_o;

  int fail_count;
  int pending;
  int words;
  int reduced;
  int muted;

  int cycle_count = 0;
  int ready_hold = 0;
  int settings_count = 0;
  bit sender_steady = 1'b1;
  bit sink_steady = 1'b1;
  logic [DataW-1:0] thr_now = ThrReset;

  audio_dynamic_range_compressor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_in_i      (sample_in_i),
    .start_of_block_i (start_of_block_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_out_o     (sample_out_o),
    .gain_applied_o   (gain_applied_o)
  );

  compressor_result_monitor u_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .sample_in_i      (sample_in_i),
    .start_of_block_i (start_of_block_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_out_i     (sample_out_o),
    .gain_applied_i   (gain_applied_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .words_o          (words),
    .reduced_o        (reduced),
    .muted_o          (muted)
  );

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $error("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output sink with random stalls
  always @(posedge clk_i) begin
    if (sink_steady) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold  <= pick_gap();
    end else begin
      out_ready_i <= 1'b1;
      ready_hold  <= $urandom_range(0, 5);
    end
  end

  function automatic logic [DataW-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'd65535;
      3:       return 16'($urandom_range(0, 2048));
      default: return 16'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_ratio();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd255;
      2:       return 16'd256;
      3:       return 16'd65535;
      4, 5:    return 16'($urandom_range(256, 2048));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_release();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd65535;
      2:       return ReleaseReset;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // peak level of one burst, some of them just above the threshold
  function automatic int pick_level(input logic [DataW-1:0] thr);
    case ($urandom_range(0, 5))
      0, 1:    return 32768;
      2:       return 8192;
      3:       return 1024;
      4:       return 64;
      default: return (int'(thr) + 256 > 32768) ? 32768 : int'(thr) + 256;
    endcase
  endfunction

  function automatic logic [DataW-1:0] shaped_sample(input int level);
    int mag;
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    mag = $urandom_range(0, level);
    if ($urandom_range(0, 1) == 1) return 16'(-mag);
    return 16'((mag > 32767) ? 32767 : mag);
  endfunction

  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // write all three registers, optionally poking the unmapped index first
  task automatic program_regs(input logic [DataW-1:0] thr, input logic [DataW-1:0] ratio,
                              input logic [DataW-1:0] rel, input bit poke_spare);
    if (poke_spare) reg_write(RegSpare, 16'($urandom()));
    reg_write(RegThreshold, thr);
    reg_write(RegRatio, ratio);
    reg_write(RegRelease, rel);
    cfg_we_i <= 1'b0;
    thr_now = thr;
    settings_count++;
    @(posedge clk_i);
  endtask

  // present one word, wait for it to be taken, then maybe idle
  task automatic push_word(input logic [DataW-1:0] smp, input logic sob);
    int gap;
    in_valid_i       <= 1'b1;
    sample_in_i      <= smp;
    start_of_block_i <= sob;
    do @(posedge clk_i); while (!in_ready_o);
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every predicted word has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_pace(input int mode);
    sender_steady = (mode == 0) || (mode == 2);
    sink_steady  <= (mode == 0) || (mode == 1);
  endtask

  initial begin
    int sent;
    int k;
    int burst_len;
    int level;
    bit sob;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, zero threshold mutes everything above zero
    set_pace(0);
    push_word(16'sd0, 1'b1);
    push_word(16'sd32767, 1'b0);
    push_word(-16'sd32768, 1'b0);
    push_word(-16'sd1, 1'b0);
    push_word(16'sd100, 1'b0);
    push_word(16'sd0, 1'b0);
    push_word(-16'sd32768, 1'b1);
    wait_idle();

    // threshold at full scale keeps unity gain, full-scale negative passes through
    program_regs(16'd32768, 16'd65535, 16'd65535, 1'b1);
    push_word(-16'sd32768, 1'b1);
    push_word(16'sd32767, 1'b0);
    push_word(-16'sd32768, 1'b0);
    push_word(16'sd0, 1'b0);
    wait_idle();

    // around the threshold, no release at all
    program_regs(16'd1000, 16'd65535, 16'd0, 1'b0);
    push_word(16'sd20000, 1'b1);
    push_word(-16'sd5, 1'b0);
    push_word(16'sd999, 1'b1);
    push_word(16'sd1000, 1'b1);
    push_word(16'sd1001, 1'b1);
    push_word(-16'sd32768, 1'b0);
    wait_idle();

    // ratio zero treated as one
    program_regs(16'd0, 16'd0, 16'd65535, 1'b0);
    push_word(16'sd12345, 1'b1);
    push_word(-16'sd12345, 1'b0);
    push_word(-16'sd32768, 1'b0);
    wait_idle();

    // top threshold, ratio just under one
    program_regs(16'd65535, 16'd255, 16'd1, 1'b1);
    push_word(-16'sd32768, 1'b1);
    push_word(16'sd32767, 1'b0);
    wait_idle();

    // random bursts under random settings
    for (int phase = 0; phase < NumPhases; phase++) begin
      program_regs(pick_threshold(), pick_ratio(), pick_release(), $urandom_range(0, 3) == 0);
      set_pace(phase % 4);
      sent = 0;
      while (sent < PhaseWords) begin
        burst_len = $urandom_range(4, 48);
        level     = pick_level(thr_now);
        for (k = 0; k < burst_len && sent < PhaseWords; k++) begin
          sob = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 49) == 0);
          push_word(shaped_sample(level), sob);
          sent++;
          // in phase 3 the sender holds off mid-phase until the block has drained
          if (phase == 3 && sent == PhaseWords / 2) wait_idle();
        end
      end
      wait_idle();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (pending != 0) $error("%0d predicted words never came back", pending);

    $display("run covered %0d words over %0d register settings", words, settings_count);
    $display("gain reduced on %0d words, fully muted on %0d", reduced, muted);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* audio_dynamic_range_compressor.f */
+incdir+hw/rtl
hw/rtl/adrc_pkg.sv
hw/rtl/adrc_useq.sv
hw/rtl/adrc_datapath.sv
hw/rtl/audio_dynamic_range_compressor.sv
tb/sv/compressor_result_monitor.sv
tb/sv/audio_dynamic_range_compressor_tb.sv
